// ===== sv/pdtq_pkg.sv =====
// Package with the shared types, codes and defaults of the process dispatcher.
package pdtq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TimeWidthDef  = 16;
  localparam int unsigned FieldW        = 16;

  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_TICK    = 3'd1,
    FUNC_SWITCH  = 3'd2,
    FUNC_IO_DONE = 3'd3,
    FUNC_OTHER   = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_SWITCHED     = 4'd0,
    ST_BLOCKED_JOBS = 4'd1,
    ST_NO_JOBS      = 4'd2,
    ST_BLOCKED_EMPTY = 4'd3,
    ST_MOVED        = 4'd4,
    ST_UNIMPL       = 4'd5,
    ST_LOADED       = 4'd6,
    ST_TO_BLOCKED   = 4'd7,
    ST_FINISHED     = 4'd8,
    ST_DECREMENTED  = 4'd9,
    ST_ACCEPTED     = 4'd10,
    ST_REJECTED     = 4'd11
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_MOVE,
    S_RESPOND
  } state_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [FieldW-1:0] job_cpu_time;
    logic [FieldW-1:0] job_start_time;
    logic [FieldW-1:0] job_io_time;
    logic [FieldW-1:0] job_number;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              running_valid;
    logic [FieldW-1:0] running_cpu_time;
    logic [FieldW-1:0] running_start_time;
    logic [FieldW-1:0] running_io_time;
    logic [FieldW-1:0] running_number;
  } out_item_t;

  typedef struct packed {
    logic    cap_in;
    logic    push_new;
    logic    pop_ready;
    logic    load_run;
    logic    push_run_ready;
    logic    push_run_blocked;
    logic    clear_run;
    logic    dec_cpu;
    logic    move_rd;
    logic    set_status;
    status_e status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       ready_empty;
    logic       blocked_empty;
    logic       run_present;
    logic       cpu_le1;
    logic       io_nz;
    logic       move_pend;
  } dp_stat_t;

endpackage

// ===== sv/pdtq_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module pdtq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pdtq_ctrl.sv =====
// Controller state machine that sequences each dispatcher item.
module pdtq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pdtq_pkg::dp_stat_t stat_i,
  output pdtq_pkg::ctl_cmd_t cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  import pdtq_pkg::*;

  state_e  state_q, state_d;
  status_e idle_st;
  logic    loads;

  assign idle_st = stat_i.blocked_empty ? ST_NO_JOBS : ST_BLOCKED_JOBS;
  assign loads   = ((func_e'(stat_i.func) == FUNC_TICK && !stat_i.run_present) ||
                    func_e'(stat_i.func) == FUNC_SWITCH) && !stat_i.ready_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (loads) begin
          state_d = S_LOAD;
        end else if (func_e'(stat_i.func) == FUNC_IO_DONE && !stat_i.blocked_empty) begin
          state_d = S_MOVE;
        end else begin
          state_d = S_RESPOND;
        end
      end
      S_LOAD: state_d = S_RESPOND;
      S_MOVE: begin
        if (stat_i.blocked_empty && !stat_i.move_pend) begin
          state_d = S_RESPOND;
        end
      end
      S_RESPOND: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.status = ST_UNIMPL;
    unique case (state_q)
      S_IDLE: cmd_o.cap_in = start_i;
      S_EXEC: begin
        cmd_o.set_status = 1'b1;
        unique case (func_e'(stat_i.func))
          FUNC_ADD: begin
            if (stat_i.full) begin
              cmd_o.status = ST_REJECTED;
            end else begin
              cmd_o.push_new = 1'b1;
              cmd_o.status   = ST_ACCEPTED;
            end
          end
          FUNC_TICK: begin
            if (!stat_i.run_present) begin
              if (stat_i.ready_empty) begin
                cmd_o.status = idle_st;
              end else begin
                cmd_o.pop_ready  = 1'b1;
                cmd_o.set_status = 1'b0;
              end
            end else if (stat_i.cpu_le1) begin
              cmd_o.clear_run = 1'b1;
              if (stat_i.io_nz) begin
                cmd_o.push_run_blocked = 1'b1;
                cmd_o.status           = ST_TO_BLOCKED;
              end else begin
                cmd_o.status = ST_FINISHED;
              end
            end else begin
              cmd_o.dec_cpu = 1'b1;
              cmd_o.status  = ST_DECREMENTED;
            end
          end
          FUNC_SWITCH: begin
            if (stat_i.ready_empty) begin
              cmd_o.status = idle_st;
            end else begin
              cmd_o.pop_ready  = 1'b1;
              cmd_o.set_status = 1'b0;
            end
          end
          FUNC_IO_DONE: begin
            if (stat_i.blocked_empty) begin
              cmd_o.status = ST_BLOCKED_EMPTY;
            end else begin
              cmd_o.set_status = 1'b0;
            end
          end
          default: cmd_o.status = ST_UNIMPL;
        endcase
      end
      S_LOAD: begin
        cmd_o.load_run   = 1'b1;
        cmd_o.set_status = 1'b1;
        if (func_e'(stat_i.func) == FUNC_SWITCH) begin
          cmd_o.push_run_ready = stat_i.run_present;
          cmd_o.status         = ST_SWITCHED;
        end else begin
          cmd_o.status = ST_LOADED;
        end
      end
      S_MOVE: begin
        cmd_o.move_rd = !stat_i.blocked_empty;
        if (stat_i.blocked_empty && !stat_i.move_pend) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_MOVED;
        end
      end
      S_RESPOND: cmd_o.set_status = 1'b0;
      default: cmd_o.set_status = 1'b0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESPOND);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("Controller did not go busy after accepting an item.");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");
  a_load_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> $past(state_q) == S_EXEC)
    else $error("Load step was not preceded by a decode step.");
`endif

endmodule

// ===== sv/pdtq_datapath.sv =====
// Datapath with the ready and blocked queues, the running slot and the result register.
module pdtq_datapath #(
  parameter int unsigned QUEUE_DEPTH = pdtq_pkg::QueueDepthDef,
  parameter int unsigned TIME_WIDTH  = pdtq_pkg::TimeWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdtq_pkg::in_item_t  in_i,
  input  pdtq_pkg::ctl_cmd_t  cmd_i,
  output pdtq_pkg::dp_stat_t  stat_o,
  output pdtq_pkg::out_item_t res_o
);

  import pdtq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned JobW = 4 * TIME_WIDTH;
  localparam logic [CntW:0]   DepthC  = (CntW + 1)'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  in_item_t            in_q;
  status_e             status_q, status_d;
  logic [IdxW-1:0]     rhead_q, rhead_d, bhead_q, bhead_d;
  logic [CntW-1:0]     rcount_q, rcount_d, bcount_q, bcount_d;
  logic                present_q, present_d;
  logic                pend_q, pend_d;
  logic [TIME_WIDTH-1:0] cpu_q, cpu_d, start_q, start_d, io_q, io_d, num_q, num_d;

  logic [CntW:0]       rsum, bsum, total;
  logic [IdxW-1:0]     rtail, btail;
  logic                rdy_we, blk_we;
  logic [JobW-1:0]     rdy_wdata, rdy_rdata, blk_wdata, blk_rdata, new_job, run_job;

  assign rsum  = (CntW + 1)'(rhead_q) + (CntW + 1)'(rcount_q);
  assign bsum  = (CntW + 1)'(bhead_q) + (CntW + 1)'(bcount_q);
  assign rtail = (rsum >= DepthC) ? IdxW'(rsum - DepthC) : IdxW'(rsum);
  assign btail = (bsum >= DepthC) ? IdxW'(bsum - DepthC) : IdxW'(bsum);
  assign total = (CntW + 1)'(rcount_q) + (CntW + 1)'(bcount_q) + (CntW + 1)'(present_q);

  assign new_job = {TIME_WIDTH'(in_q.job_cpu_time), TIME_WIDTH'(in_q.job_start_time),
                    TIME_WIDTH'(in_q.job_io_time), TIME_WIDTH'(in_q.job_number)};
  assign run_job = {cpu_q, start_q, io_q, num_q};

  assign rdy_we    = cmd_i.push_new || cmd_i.push_run_ready || pend_q;
  assign rdy_wdata = pend_q ? blk_rdata : (cmd_i.push_new ? new_job : run_job);
  assign blk_we    = cmd_i.push_run_blocked;
  assign blk_wdata = {{TIME_WIDTH{1'b0}}, start_q, {TIME_WIDTH{1'b0}}, num_q};

  pdtq_ram #(
    .WIDTH(JobW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (rdy_we),
    .waddr_i(rtail),
    .wdata_i(rdy_wdata),
    .re_i   (cmd_i.pop_ready),
    .raddr_i(rhead_q),
    .rdata_o(rdy_rdata)
  );

  pdtq_ram #(
    .WIDTH(JobW),
    .DEPTH(QUEUE_DEPTH)
  ) u_blocked_ram (
    .clk_i  (clk_i),
    .we_i   (blk_we),
    .waddr_i(btail),
    .wdata_i(blk_wdata),
    .re_i   (cmd_i.move_rd),
    .raddr_i(bhead_q),
    .rdata_o(blk_rdata)
  );

  always_comb begin
    rhead_d   = rhead_q;
    rcount_d  = rcount_q;
    bhead_d   = bhead_q;
    bcount_d  = bcount_q;
    present_d = present_q;
    cpu_d     = cpu_q;
    start_d   = start_q;
    io_d      = io_q;
    num_d     = num_q;
    status_d  = status_q;
    pend_d    = cmd_i.move_rd;
    if (rdy_we) begin
      rcount_d = rcount_q + 1'b1;
    end else if (cmd_i.pop_ready) begin
      rcount_d = rcount_q - 1'b1;
    end
    if (cmd_i.pop_ready) begin
      rhead_d = (rhead_q == LastIdx) ? '0 : rhead_q + 1'b1;
    end
    if (cmd_i.move_rd) begin
      bhead_d  = (bhead_q == LastIdx) ? '0 : bhead_q + 1'b1;
      bcount_d = bcount_q - 1'b1;
    end else if (blk_we) begin
      bcount_d = bcount_q + 1'b1;
    end
    if (cmd_i.load_run) begin
      present_d = 1'b1;
      cpu_d     = rdy_rdata[4*TIME_WIDTH-1 -: TIME_WIDTH];
      start_d   = rdy_rdata[3*TIME_WIDTH-1 -: TIME_WIDTH];
      io_d      = rdy_rdata[2*TIME_WIDTH-1 -: TIME_WIDTH];
      num_d     = rdy_rdata[TIME_WIDTH-1 -: TIME_WIDTH];
    end else if (cmd_i.clear_run) begin
      present_d = 1'b0;
      cpu_d     = '0;
      start_d   = '0;
      io_d      = '0;
      num_d     = '0;
    end else if (cmd_i.dec_cpu) begin
      cpu_d = cpu_q - 1'b1;
    end
    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhead_q   <= '0;
      rcount_q  <= '0;
      bhead_q   <= '0;
      bcount_q  <= '0;
      present_q <= 1'b0;
      pend_q    <= 1'b0;
      cpu_q     <= '0;
      start_q   <= '0;
      io_q      <= '0;
      num_q     <= '0;
    end else begin
      rhead_q   <= rhead_d;
      rcount_q  <= rcount_d;
      bhead_q   <= bhead_d;
      bcount_q  <= bcount_d;
      present_q <= present_d;
      pend_q    <= pend_d;
      cpu_q     <= cpu_d;
      start_q   <= start_d;
      io_q      <= io_d;
      num_q     <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_q <= in_i;
    end
    status_q <= status_d;
  end

  assign stat_o.func          = in_q.func;
  assign stat_o.full          = (total >= DepthC);
  assign stat_o.ready_empty   = (rcount_q == '0);
  assign stat_o.blocked_empty = (bcount_q == '0);
  assign stat_o.run_present   = present_q;
  assign stat_o.cpu_le1       = (cpu_q <= TIME_WIDTH'(1));
  assign stat_o.io_nz         = (io_q != '0);
  assign stat_o.move_pend     = pend_q;

  assign res_o.status             = status_q;
  assign res_o.running_valid      = present_q;
  assign res_o.running_cpu_time   = FieldW'(cpu_q);
  assign res_o.running_start_time = FieldW'(start_q);
  assign res_o.running_io_time    = FieldW'(io_q);
  assign res_o.running_number     = FieldW'(num_q);

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= DepthC)
    else $error("More jobs held than the queue depth allows.");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_ready |-> rcount_q != '0)
    else $error("Ready queue popped while empty.");
  a_load_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_run |-> $past(cmd_i.pop_ready))
    else $error("Running slot loaded without a preceding ready read.");
`endif

endmodule

// ===== sv/process_dispatcher_two_queue.sv =====
// Top level of the FIFO process dispatcher with ready and blocked queues.
// An item is taken when start is high and busy is low; exactly one result follows, shown
// for one cycle with done_o high, and it cannot be held off. An add, a tick that needs no
// queue read, a switch or tick with nothing to load, an empty I/O-complete and an unknown
// code go from the decode state straight to the result state. A tick or switch that loads
// the running slot passes through a load state first, because the ready queue memory has a
// registered read. An I/O-complete with blocked jobs passes through a move state, moving
// one job per cycle from the blocked memory read port to the ready memory write port
// until the blocked queue is empty. The result shows in the result state, the last before
// idle. Every result reports the running slot after the item.
module process_dispatcher_two_queue #(
  parameter int unsigned QUEUE_DEPTH = pdtq_pkg::QueueDepthDef,
  parameter int unsigned TIME_WIDTH  = pdtq_pkg::TimeWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pdtq_pkg::in_item_t  item_i,
  output logic                done_o,
  output pdtq_pkg::out_item_t result_o
);

  import pdtq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pdtq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  pdtq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (item_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .res_o (result_o)
  );

endmodule
